// ----- design/md5_pkg.sv -----
// Package with the MD5 constants, tables and shared types of the hash engine.
`timescale 1ns / 1ps

package md5_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;

   typedef logic [3:0][WORD_W-1:0] md5_chain_type;

   // Entry 0 is word A, entry 3 is word D.
   localparam md5_chain_type MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {phase, round[1:0]}.
   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_LOAD,
      S_ROUND,
      S_FINISH,
      S_DONE
   } md5_state_type;

   typedef struct packed {
      logic init_chain;
      logic load_work;
      logic do_round;
      logic add_chain;
   } md5_ctl_type;

   // Block word used by a given round.
   function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
      logic [3:0] idx;
      logic [3:0] res;
      idx = rnd[3:0];
      unique case (rnd[5:4])
         2'd0: res = idx;
         2'd1: res = 4'((idx << 2) + idx + 4'd1);
         2'd2: res = 4'((idx << 1) + idx + 4'd5);
         2'd3: res = 4'((idx << 3) - idx);
         default: res = idx;
      endcase
      return res;
   endfunction

endpackage

// ----- design/md5_hash_engine_top.sv -----
// Top level of the byte-serial MD5 hash engine: byte packing, padding and sequencing.
`timescale 1ns / 1ps

// Byte-serial MD5 engine. One transaction carries at most one message byte and
// may mark the end of the message. A byte that does not complete a 64-byte block
// leaves the input free for the next one. The byte that completes a block starts
// the compression: the working words are loaded, the rounds run through the single
// shared round unit (one round per cycle, block words read from a 16-word RAM one
// round ahead) and the result is added into the chaining words; the input stalls
// until that is done. A transaction that ends the message then feeds the 0x80
// marker, zero bytes and the eight length bytes through the same byte path, one
// per cycle while no compression runs, with one or two compressions on the way,
// and then the digest is ready.
// The digest waits in an output register; the next message is taken while it
// waits, but its own digest is held back until the earlier one has been taken.
module md5_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_high,
   output logic [63:0] rsp_digest_low
);

   localparam int ADDR_W = $clog2(md5_pkg::BLOCK_WORDS);

   function automatic logic [31:0] swap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   md5_pkg::md5_state_type state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [23:0] partial_ff, partial_in;
   logic        pad_ff, pad_in;
   logic        mark_ff, mark_in;
   logic        lenph_ff, lenph_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] dig_hi_ff, dig_hi_in;
   logic [63:0] dig_lo_ff, dig_lo_in;

   md5_pkg::md5_ctl_type   ctl;
   md5_pkg::md5_chain_type chain;

   logic              absorb_en;
   logic [7:0]        absorb_byte;
   logic              blk_full;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [31:0]       ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [31:0]       ram_rdata;

   assign blk_full = (cnt_ff[5:0] == 6'd63);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         partial_ff   <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         lenph_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rnd_ff       <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         partial_ff   <= partial_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         lenph_ff     <= lenph_in;
         rsp_valid_ff <= rsp_valid_in;
         rnd_ff       <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      bitlen_ff <= bitlen_in;
      dig_hi_ff <= dig_hi_in;
      dig_lo_ff <= dig_lo_in;
   end

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      cnt_in       = cnt_ff;
      partial_in   = partial_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      lenph_in     = lenph_ff;
      bitlen_in    = bitlen_ff;
      dig_hi_in    = dig_hi_ff;
      dig_lo_in    = dig_lo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl          = '0;
      absorb_en    = 1'b0;
      absorb_byte  = '0;
      ram_raddr    = md5_pkg::md5_msg_index(6'(rnd_ff + 6'd1));
      req_stall    = (state_ff != md5_pkg::S_IDLE);

      unique case (state_ff)
         md5_pkg::S_IDLE: begin
            if (req_valid) begin
               absorb_en   = req_byte_valid;
               absorb_byte = req_data_byte;
               if (req_last) begin
                  pad_in   = 1'b1;
                  mark_in  = 1'b0;
                  lenph_in = 1'b0;
               end
               if (req_byte_valid && blk_full) begin
                  state_in = md5_pkg::S_LOAD;
               end else if (req_last) begin
                  state_in = md5_pkg::S_PAD;
               end
            end
         end
         md5_pkg::S_PAD: begin
            absorb_en = 1'b1;
            if (!mark_ff) begin
               absorb_byte = md5_pkg::PAD_MARK;
               mark_in     = 1'b1;
               bitlen_in   = {cnt_ff[60:0], 3'b000};
            end else if (lenph_ff || cnt_ff[5:0] == 6'd56) begin
               // Length bytes start on a multiple of eight, so the count picks the byte.
               absorb_byte = bitlen_ff[{cnt_ff[2:0], 3'b000} +: 8];
               lenph_in    = 1'b1;
            end else begin
               absorb_byte = '0;
            end
            if (blk_full) begin
               state_in = md5_pkg::S_LOAD;
            end
         end
         md5_pkg::S_LOAD: begin
            ctl.load_work = 1'b1;
            ram_raddr     = md5_pkg::md5_msg_index(6'd0);
            rnd_in        = '0;
            state_in      = md5_pkg::S_ROUND;
         end
         md5_pkg::S_ROUND: begin
            ctl.do_round = 1'b1;
            rnd_in       = 6'(rnd_ff + 6'd1);
            if (rnd_ff == 6'd63) begin
               state_in = md5_pkg::S_FINISH;
            end
         end
         md5_pkg::S_FINISH: begin
            ctl.add_chain = 1'b1;
            if (pad_ff && lenph_ff) begin
               state_in = md5_pkg::S_DONE;
            end else if (pad_ff) begin
               state_in = md5_pkg::S_PAD;
            end else begin
               state_in = md5_pkg::S_IDLE;
            end
         end
         md5_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               dig_hi_in      = {swap32(chain[0]), swap32(chain[1])};
               dig_lo_in      = {swap32(chain[2]), swap32(chain[3])};
               ctl.init_chain = 1'b1;
               cnt_in         = '0;
               partial_in     = '0;
               pad_in         = 1'b0;
               mark_in        = 1'b0;
               lenph_in       = 1'b0;
               state_in       = md5_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::S_IDLE;
         end
      endcase

      // Shared byte path: pack little-endian and write each finished word.
      ram_we    = absorb_en && (cnt_ff[1:0] == 2'd3);
      ram_waddr = cnt_ff[5:2];
      ram_wdata = {absorb_byte, partial_ff};
      if (absorb_en) begin
         cnt_in = cnt_ff + 64'd1;
         case (cnt_ff[1:0])
            2'd0: partial_in = {16'd0, absorb_byte};
            2'd1: partial_in = {8'd0, absorb_byte, partial_ff[7:0]};
            2'd2: partial_in = {absorb_byte, partial_ff[15:0]};
            default: partial_in = '0;
         endcase
      end
   end

   md5_ram #(
      .WIDTH(md5_pkg::WORD_W),
      .DEPTH(md5_pkg::BLOCK_WORDS)
   ) u_block_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   md5_round_unit u_round (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rnd     (rnd_ff),
      .msg_word(ram_rdata),
      .chain   (chain)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_high = dig_hi_ff;
   assign rsp_digest_low  = dig_lo_ff;

`ifndef SYNTHESIS
   // A compression only starts on a block boundary.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::S_LOAD) |-> (cnt_ff[5:0] == 6'd0))
      else $error("compression started off a block boundary");

   // The block RAM is never written while its words are being read by the rounds.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == md5_pkg::S_IDLE || state_ff == md5_pkg::S_PAD))
      else $error("block RAM written during compression");

   // The last round is always followed by the chaining add.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::S_ROUND && rnd_ff == 6'd63) |=> (state_ff == md5_pkg::S_FINISH))
      else $error("round sequence did not end in the chaining add");

   // A new digest only appears when the message state is cleared for the next one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::S_DONE && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && cnt_ff == 64'd0 && !pad_ff && state_ff == md5_pkg::S_IDLE))
      else $error("digest issued without clearing the message state");

   // Padding always ends on a full block.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5_pkg::S_DONE) |-> (cnt_ff[5:0] == 6'd0 && lenph_ff))
      else $error("digest ready before the length block was hashed");
`endif

endmodule

// ----- design/md5_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/md5_round_unit.sv -----
// MD5 round unit: working registers, one round per cycle, and the chaining words.
`timescale 1ns / 1ps

module md5_round_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::md5_ctl_type  ctl,
   input  logic [5:0]            rnd,
   input  logic [31:0]           msg_word,
   output md5_pkg::md5_chain_type chain
);

   md5_pkg::md5_chain_type chain_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;

   logic [31:0] k_w;
   logic [4:0]  s_w;
   logic [31:0] f_w;
   logic [31:0] sum_w;
   logic [63:0] rot_wide_w;
   logic [31:0] new_b_w;

   always_comb begin
      k_w = md5_pkg::MD5_K[rnd];
      s_w = md5_pkg::MD5_S[{rnd[5:4], rnd[1:0]}];
      case (rnd[5:4])
         2'd0: f_w = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_w = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_w = b_ff ^ c_ff ^ d_ff;
         default: f_w = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum_w      = a_ff + f_w + k_w + msg_word;
      // Rotate left: the upper half of the doubled word shifted left.
      rot_wide_w = {sum_w, sum_w} << s_w;
      new_b_w    = b_ff + rot_wide_w[63:32];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (ctl.do_round) begin
         a_ff <= d_ff;
         b_ff <= new_b_w;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init_chain) begin
         chain_ff <= md5_pkg::MD5_IV;
      end else if (ctl.add_chain) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
      end
   end

   assign chain = chain_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the byte-serial MD5 hash engine, with its digest scoreboard.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCH_LIMIT  = 5000;
   localparam int END_WAIT     = 250;
   localparam int TARGET_ITEMS = 1650;
   localparam int QUIET_AFTER  = 1500;
   localparam int HOLD_CYCLES  = 800;

   localparam logic [31:0] MIX_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROTATE_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } digest_pair_type;

   class md5_scoreboard;
      logic [31:0] chain [4];
      logic [31:0] block_w [16];
      logic [23:0] partial;
      logic [63:0] msg_bytes;
      digest_pair_type expected_digests [$];
      int errors;
      int digests_checked;

      function new();
         errors = 0;
         digests_checked = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hefcdab89;
         chain[2] = 32'h98badcfe;
         chain[3] = 32'h10325476;
         foreach (block_w[k]) block_w[k] = '0;
         partial = '0;
         msg_bytes = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int s);
         return (x << s) | (x >> (32 - s));
      endfunction

      function logic [31:0] swap_bytes(logic [31:0] w);
         return {w[7:0], w[15:8], w[23:16], w[31:24]};
      endfunction

      function void compress();
         logic [31:0] a, b, c, d, f, tmp;
         int g, phase;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (int i = 0; i < 64; i++) begin
            phase = i / 16;
            case (phase)
               0: begin
                  f = (b & c) | (~b & d);
                  g = i;
               end
               1: begin
                  f = (d & b) | (~d & c);
                  g = (5 * i + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * i + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * i) % 16;
               end
            endcase
            tmp = d;
            d = c;
            c = b;
            b = b + rotl(a + f + MIX_CONST[i] + block_w[g], ROTATE_AMT[phase * 4 + i % 4]);
            a = tmp;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      function void absorb(logic [7:0] b);
         logic [1:0] pos;
         logic [3:0] idx;
         logic [31:0] word;
         pos = msg_bytes[1:0];
         idx = msg_bytes[5:2];
         word = {8'h00, partial} | (32'(b) << (8 * pos));
         if (pos == 2'd3) begin
            block_w[idx] = word;
            partial = '0;
            if (idx == 4'd15) compress();
         end else begin
            partial = word[23:0];
         end
         msg_bytes = msg_bytes + 64'd1;
      endfunction

      // Called for every accepted input transaction.
      function void note_item(logic [7:0] data, logic byte_valid, logic last);
         logic [63:0] bit_len;
         digest_pair_type d;
         if (byte_valid) absorb(data);
         if (!last) return;
         bit_len = msg_bytes << 3;
         absorb(PAD_BYTE);
         while (msg_bytes[5:0] != 6'd56) absorb(8'h00);
         for (int n = 0; n < 8; n++) absorb(bit_len[8 * n +: 8]);
         d.high = {swap_bytes(chain[0]), swap_bytes(chain[1])};
         d.low  = {swap_bytes(chain[2]), swap_bytes(chain[3])};
         expected_digests.push_back(d);
         restart();
      endfunction

      function void check_digest(logic [63:0] high, logic [63:0] low);
         digest_pair_type d;
         digests_checked++;
         if (expected_digests.size() == 0) begin
            $display("%0t: unexpected digest, expected none, actual %h %h", $time, high, low);
            errors++;
            return;
         end
         d = expected_digests.pop_front();
         if (high !== d.high) begin
            $display("%0t: digest_high mismatch, expected %h, actual %h", $time, d.high, high);
            errors++;
         end
         if (low !== d.low) begin
            $display("%0t: digest_low mismatch, expected %h, actual %h", $time, d.low, low);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest_high;
   logic [63:0] rsp_digest_low;

   md5_scoreboard sb;
   bit idle_on = 1'b1;
   int items_sent = 0;
   int quiet_cycles = 0;

   md5_hash_engine_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_high (rsp_digest_high),
      .rsp_digest_low  (rsp_digest_low)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one transaction and returns at the edge where it is taken.
   task automatic send_item(logic [7:0] data, logic byte_valid, logic last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_byte_valid <= byte_valid;
      req_last       <= last;
      do @(posedge clock); while (req_stall);
      sb.note_item(data, byte_valid, last);
      if (byte_valid || last) items_sent++;
   endtask

   task automatic send_message(int len, bit empty_end);
      for (int k = 0; k < len; k++) begin
         // Now and then a transaction with no byte and no end mark.
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !empty_end);
      end
      if (empty_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_digest(rsp_digest_high, rsp_digest_low);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int gap;
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sb.digests_checked >= 10) begin
            // Long hold-off so the output register and the next digest back up into req_stall.
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : req_side
      int sel, len;
      bit empty_end;
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= 8'h00;
      req_byte_valid <= 1'b0;
      req_last       <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, "abc", single extreme bytes, idle and empty end items.
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);

      while (items_sent < TARGET_ITEMS) begin
         if (items_sent >= QUIET_AFTER) idle_on = 1'b0;
         sel = $urandom_range(0, 19);
         if (sel < 10)
            len = $urandom_range(0, 12);
         else if (sel < 13)
            len = $urandom_range(52, 68);
         else if (sel < 14)
            len = $urandom_range(116, 132);
         else if (sel < 15)
            len = $urandom_range(1, 200);
         else
            len = $urandom_range(13, 51);
         empty_end = ($urandom_range(0, 3) == 0);
         send_message(len, empty_end);
      end
      req_valid <= 1'b0;

      while (sb.expected_digests.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
